// File: rtl/core/oversampled_polyphase_filter_front_core_macros.svh
// Assertion macros for the polyphase filter front end
`ifndef OVERSAMPLED_POLYPHASE_FILTER_FRONT_CORE_MACROS_SVH
`define OVERSAMPLED_POLYPHASE_FILTER_FRONT_CORE_MACROS_SVH

// same-cycle implication
`define OPF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define OPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/opf_pkg.sv
// Package: sizes, codes, controller states and command struct
`default_nettype none
package opf_pkg;
   localparam int BRANCHES        = 32;
   localparam int TAPS_PER_BRANCH = 8;
   localparam int HOP             = 16;
   localparam int SAMPLE_BITS     = 16;
   localparam int COEFF_BITS      = 16;
   localparam int TAP_COUNT       = BRANCHES * TAPS_PER_BRANCH;
   localparam int ADDR_BITS       = $clog2(TAP_COUNT);
   localparam int BR_BITS         = $clog2(BRANCHES);
   localparam int TAP_BITS        = (TAPS_PER_BRANCH > 1) ? $clog2(TAPS_PER_BRANCH) : 1;
   localparam int HOP_BITS        = (HOP > 1) ? $clog2(HOP) : 1;
   localparam int PROD_BITS       = SAMPLE_BITS + COEFF_BITS;
   localparam int ACC_BITS        = PROD_BITS + TAP_BITS;
   localparam int PHASE_STEP      = (BRANCHES - (HOP % BRANCHES)) % BRANCHES;

   localparam int INDEX_W = 8;
   localparam int VALUE_W = 16;
   localparam int BIN_W   = 5;
   localparam int OUT_W   = 35;

   localparam logic FUNC_COEFF  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_LOAD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                 tap_we;
      logic [ADDR_BITS-1:0] tap_addr;
      logic                 samp_we;
      logic                 samp_zero;
      logic [ADDR_BITS-1:0] samp_addr;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_tap_addr;
      logic [ADDR_BITS-1:0] rd_samp_addr;
      logic                 acc_clear;
      logic                 load_out;
      logic [BR_BITS-1:0]   bin;
   } cmd_type;
endpackage
`default_nettype wire

// File: rtl/core/opf_ctrl.sv
// Controller: clearing pass, frame fill, per-bin tap sequencing, result handshake
`default_nettype none
module opf_ctrl
   import opf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_func,
   input  wire logic [INDEX_W-1:0]   req_coeff_index,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output cmd_type                   cmd
);
   state_type            state_ff, state_in;
   logic [HOP_BITS-1:0]  fill_ff, fill_in;
   logic [ADDR_BITS-1:0] base_ff, base_in;
   logic [BR_BITS-1:0]   phase_ff, phase_in;
   logic [BR_BITS-1:0]   k_ff, k_in;
   logic [TAP_BITS-1:0]  p_ff, p_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic                 drain_ff, drain_in;
   logic [BR_BITS-1:0]   branch;
   logic [ADDR_BITS-1:0] tap_off;
   logic                 accept;

   assign accept  = req_valid && (state_ff == ST_IDLE);
   // output k carries branch (k - shift) mod BRANCHES
   assign branch  = k_ff - phase_ff;
   assign tap_off = ADDR_BITS'({p_ff, branch});

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      base_in  = base_ff;
      phase_in = phase_ff;
      k_in     = k_ff;
      p_in     = p_ff;
      clr_in   = clr_ff;
      drain_in = drain_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_BITS'(TAP_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && req_func == FUNC_SAMPLE) begin
               if (fill_ff == HOP_BITS'(HOP - 1)) begin
                  fill_in  = '0;
                  base_in  = base_ff - ADDR_BITS'(HOP);
                  k_in     = '0;
                  p_in     = '0;
                  state_in = ST_ISSUE;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            p_in = p_ff + 1'b1;
            if (p_ff == TAP_BITS'(TAPS_PER_BRANCH - 1)) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) state_in = ST_LOAD;
         end
         ST_LOAD: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) begin
               if (k_ff == BR_BITS'(BRANCHES - 1)) begin
                  phase_in = phase_ff + BR_BITS'(PHASE_STEP);
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  p_in     = '0;
                  state_in = ST_ISSUE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      rsp_valid        = (state_ff == ST_OUT);
      cmd              = '0;
      cmd.tap_addr     = ADDR_BITS'(req_coeff_index);
      cmd.rd_tap_addr  = tap_off;
      cmd.rd_samp_addr = base_ff + tap_off;
      cmd.bin          = k_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.samp_we   = 1'b1;
            cmd.samp_zero = 1'b1;
            cmd.samp_addr = clr_ff;
         end
         ST_IDLE: begin
            cmd.acc_clear = 1'b1;
            // new samples go into the slots that the frame shift discards
            cmd.samp_addr = base_ff - ADDR_BITS'(HOP) + ADDR_BITS'(fill_ff);
            cmd.samp_we   = accept && (req_func == FUNC_SAMPLE);
            cmd.tap_we    = accept && (req_func == FUNC_COEFF)
                            && ({1'b0, req_coeff_index} < 9'(TAP_COUNT));
         end
         ST_ISSUE: cmd.rd_en = 1'b1;
         ST_DRAIN: cmd.rd_en = 1'b0;
         ST_LOAD: begin
            cmd.load_out  = 1'b1;
            cmd.acc_clear = 1'b1;
         end
         ST_OUT: cmd.rd_en = 1'b0;
         default: cmd.rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         fill_ff  <= '0;
         base_ff  <= '0;
         phase_ff <= '0;
         k_ff     <= '0;
         p_ff     <= '0;
         clr_ff   <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         base_ff  <= base_in;
         phase_ff <= phase_in;
         k_ff     <= k_in;
         p_ff     <= p_in;
         clr_ff   <= clr_in;
         drain_ff <= drain_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/opf_datapath.sv
// Datapath: tap and sample memories, complex MAC, result register
`default_nettype none
module opf_datapath
   import opf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  cmd_type                     cmd,
   input  wire logic signed [VALUE_W-1:0] req_coeff_value,
   input  wire logic signed [VALUE_W-1:0] req_sample_re,
   input  wire logic signed [VALUE_W-1:0] req_sample_im,
   output logic [BIN_W-1:0]            rsp_bin_index,
   output logic signed [OUT_W-1:0]     rsp_out_re,
   output logic signed [OUT_W-1:0]     rsp_out_im,
   output logic                        rsp_last
);
   logic signed [COEFF_BITS-1:0]    tap_mem [TAP_COUNT];
   logic [2*SAMPLE_BITS-1:0]        samp_mem [TAP_COUNT];
   logic signed [COEFF_BITS-1:0]    tap_rd_ff;
   logic [2*SAMPLE_BITS-1:0]        samp_rd_ff;
   logic                            rd_v_ff, prod_v_ff;
   logic signed [PROD_BITS-1:0]     prod_re_ff, prod_im_ff;
   logic signed [ACC_BITS-1:0]      acc_re_ff, acc_im_ff;
   logic [BR_BITS-1:0]              bin_ff;
   logic signed [ACC_BITS-1:0]      out_re_ff, out_im_ff;
   logic                            last_ff;
   logic [2*SAMPLE_BITS-1:0]        samp_wdata;

   assign samp_wdata = cmd.samp_zero ? '0
      : {req_sample_re[SAMPLE_BITS-1:0], req_sample_im[SAMPLE_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (cmd.tap_we) tap_mem[cmd.tap_addr] <= req_coeff_value[COEFF_BITS-1:0];
      if (cmd.samp_we) samp_mem[cmd.samp_addr] <= samp_wdata;
      if (cmd.rd_en) begin
         tap_rd_ff  <= tap_mem[cmd.rd_tap_addr];
         samp_rd_ff <= samp_mem[cmd.rd_samp_addr];
      end
   end

   always_ff @(posedge clock) begin
      prod_re_ff <= tap_rd_ff * $signed(samp_rd_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]);
      prod_im_ff <= tap_rd_ff * $signed(samp_rd_ff[SAMPLE_BITS-1:0]);
      if (cmd.acc_clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod_v_ff) begin
         acc_re_ff <= acc_re_ff + ACC_BITS'(prod_re_ff);
         acc_im_ff <= acc_im_ff + ACC_BITS'(prod_im_ff);
      end
      if (cmd.load_out) begin
         out_re_ff <= acc_re_ff;
         out_im_ff <= acc_im_ff;
         bin_ff    <= cmd.bin;
         last_ff   <= (cmd.bin == BR_BITS'(BRANCHES - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.rd_en;
         prod_v_ff <= rd_v_ff;
      end
   end

   assign rsp_bin_index = BIN_W'(bin_ff);
   assign rsp_out_re    = OUT_W'(out_re_ff);
   assign rsp_out_im    = OUT_W'(out_im_ff);
   assign rsp_last      = last_ff;
endmodule
`default_nettype wire

// File: rtl/core/oversampled_polyphase_filter_front_core.sv
// Top level of the oversampled polyphase filter bank front end
// A coefficient item or a non-final sample item is taken and the core stays idle. The
// HOP-th sample of a frame starts the branch sums: one complex MAC pair and
// one read port per memory handle a tap per cycle for each of the BRANCHES
// results in turn, each waiting on rsp_ready; no item is taken meanwhile.
// After reset a clearing pass zeroes the 256-entry sample store, during
// which req_ready stays low.
`default_nettype none
`include "oversampled_polyphase_filter_front_core_macros.svh"
module oversampled_polyphase_filter_front_core
   import opf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_func,
   input  wire logic [INDEX_W-1:0]        req_coeff_index,
   input  wire logic signed [VALUE_W-1:0] req_coeff_value,
   input  wire logic signed [VALUE_W-1:0] req_sample_re,
   input  wire logic signed [VALUE_W-1:0] req_sample_im,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [BIN_W-1:0]               rsp_bin_index,
   output logic signed [OUT_W-1:0]        rsp_out_re,
   output logic signed [OUT_W-1:0]        rsp_out_im,
   output logic                           rsp_last
);
   cmd_type cmd;

   opf_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_coeff_index (req_coeff_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd)
   );

   opf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_coeff_value (req_coeff_value),
      .req_sample_re   (req_sample_re),
      .req_sample_im   (req_sample_im),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_out_re      (rsp_out_re),
      .rsp_out_im      (rsp_out_im),
      .rsp_last        (rsp_last)
   );

   `OPF_ASSERT_SAME(a_no_intake_while_out, clock, reset, rsp_valid, !req_ready)
   `OPF_ASSERT_SAME(a_last_on_final_bin, clock, reset, rsp_valid && rsp_last,
      rsp_bin_index == BIN_W'(BRANCHES - 1))
   `OPF_ASSERT_NEXT(a_one_item_per_bin, clock, reset, rsp_valid && rsp_ready, !rsp_valid)
endmodule
`default_nettype wire
